FILE: hdl/one_wire_temp_sensor_master_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for one_wire_temp_sensor_master_top
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_TEMP_SENSOR_MASTER_TOP_ASSERT_SVH
`define ONE_WIRE_TEMP_SENSOR_MASTER_TOP_ASSERT_SVH

// same-cycle implication
`define OWTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OWTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/owtm_pkg.sv
// ----------------------------------------------------------------------------
// owtm_pkg
// Types, constants and helpers shared by the 1-wire temperature sensor master.
// ----------------------------------------------------------------------------
`default_nettype none

package owtm_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int TICK_W     = 16;
    localparam int TEMP_W     = 16;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 24;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_REL   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CMD_GAP     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_LOW   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_LOW    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_DLY  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECOVERY    = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW  = 16'd480;
    localparam logic [CFG_W-1:0] RST_RESET_REL  = 16'd60;
    localparam logic [CFG_W-1:0] RST_CMD_GAP    = 16'd1000;
    localparam logic [CFG_W-1:0] RST_SHORT_LOW  = 16'd2;
    localparam logic [CFG_W-1:0] RST_LONG_LOW   = 16'd60;
    localparam logic [CFG_W-1:0] RST_SAMPLE_DLY = 16'd2;
    localparam logic [CFG_W-1:0] RST_RECOVERY   = 16'd60;

    localparam logic [TICK_W-1:0] WRITE0_RELEASE = 16'd2;

    // commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_CONVERT = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // ROM and function commands
    localparam logic [7:0] ROM_SKIP     = 8'hCC;
    localparam logic [7:0] FN_CONVERT   = 8'h44;
    localparam logic [7:0] FN_READ_SCR  = 8'hBE;

    localparam logic [4:0] BYTE_BITS = 5'd8;
    localparam logic [4:0] READ_BITS = 5'd16;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RST_LOW = 4'd1,
        PH_RST_REL = 4'd2,
        PH_GAP     = 4'd3,
        PH_W_LOW   = 4'd4,
        PH_W_REL   = 4'd5,
        PH_R_LOW   = 4'd6,
        PH_R_WAIT  = 4'd7,
        PH_R_REC   = 4'd8
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low;
        logic [CFG_W-1:0] reset_rel;
        logic [CFG_W-1:0] cmd_gap;
        logic [CFG_W-1:0] short_low;
        logic [CFG_W-1:0] long_low;
        logic [CFG_W-1:0] sample_dly;
        logic [CFG_W-1:0] recovery;
    } t_cfg;

    // zero-length phases last one tick
    function automatic logic [TICK_W-1:0] f_span(input logic [CFG_W-1:0] n);
        return (n == '0) ? TICK_W'(1) : n;
    endfunction

    // floor((5*raw + 4) / 8)
    function automatic logic [TEMP_W-1:0] f_tenths(input logic [TEMP_W-1:0] raw);
        logic [TEMP_W+2:0] acc;
        acc = ({3'b000, raw} << 2) + {3'b000, raw} + (TEMP_W+3)'(4);
        return acc[TEMP_W+2:3];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/one_wire_temp_sensor_master_top.sv
// ----------------------------------------------------------------------------
// one_wire_temp_sensor_master_top
// 1-wire master for a DS18B20-style temperature sensor, one bus tick per word.
// ----------------------------------------------------------------------------
// Every input word is one bus tick and produces exactly one output word. One
// word is taken per clock while the skid register is empty; the sequencer
// updates its whole state on each accepted word and its result goes into a
// two-word output buffer, so input flows while one result waits on a stalled
// output. The output word is registered there. Timing registers may be written
// at any time the block is idle; they take effect on the next sequence.
`default_nettype none

module one_wire_temp_sensor_master_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [owtm_pkg::IN_W-1:0]         s_axis_tdata,  // command[1:0], line_in[2]
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [owtm_pkg::OUT_W-1:0]       m_axis_tdata,  // drive_low[0], busy_res[1],
                                                            // done_res[2],
                                                            // temperature_tenths[18:3]
    input  wire                              i_cfg_we,
    input  wire [owtm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [owtm_pkg::CFG_W-1:0]        i_cfg_wdata
);

    owtm_pkg::t_cfg                  w_cfg;
    logic                            w_step;
    logic                            w_drive_low;
    logic                            w_busy;
    logic                            w_done;
    logic [owtm_pkg::TEMP_W-1:0]     w_temp;
    logic [owtm_pkg::OUT_W-1:0]      w_result;

    assign w_step = s_axis_tvalid && s_axis_tready;

    owtm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    owtm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_command   (s_axis_tdata[1:0]),
        .i_line_in   (s_axis_tdata[2]),
        .o_drive_low (w_drive_low),
        .o_busy      (w_busy),
        .o_done      (w_done),
        .o_temp      (w_temp)
    );

    assign w_result = {5'b00000, w_temp, w_done, w_busy, w_drive_low};

    owtm_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/owtm_cfg.sv
// ----------------------------------------------------------------------------
// owtm_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module owtm_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [owtm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [owtm_pkg::CFG_W-1:0]        i_cfg_wdata,
    output owtm_pkg::t_cfg                   o_cfg
);

    owtm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low  <= owtm_pkg::RST_RESET_LOW;
            r_cfg.reset_rel  <= owtm_pkg::RST_RESET_REL;
            r_cfg.cmd_gap    <= owtm_pkg::RST_CMD_GAP;
            r_cfg.short_low  <= owtm_pkg::RST_SHORT_LOW;
            r_cfg.long_low   <= owtm_pkg::RST_LONG_LOW;
            r_cfg.sample_dly <= owtm_pkg::RST_SAMPLE_DLY;
            r_cfg.recovery   <= owtm_pkg::RST_RECOVERY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                owtm_pkg::CFG_RESET_LOW:  r_cfg.reset_low  <= i_cfg_wdata;
                owtm_pkg::CFG_RESET_REL:  r_cfg.reset_rel  <= i_cfg_wdata;
                owtm_pkg::CFG_CMD_GAP:    r_cfg.cmd_gap    <= i_cfg_wdata;
                owtm_pkg::CFG_SHORT_LOW:  r_cfg.short_low  <= i_cfg_wdata;
                owtm_pkg::CFG_LONG_LOW:   r_cfg.long_low   <= i_cfg_wdata;
                owtm_pkg::CFG_SAMPLE_DLY: r_cfg.sample_dly <= i_cfg_wdata;
                owtm_pkg::CFG_RECOVERY:   r_cfg.recovery   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/owtm_ctrl.sv
// ----------------------------------------------------------------------------
// owtm_ctrl
// Bus sequencer: reset pulse, command bytes, read slots, temperature convert.
// Advances one tick per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module owtm_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  owtm_pkg::t_cfg                   i_cfg,
    input  wire                              i_step,
    input  wire [1:0]                        i_command,
    input  wire                              i_line_in,
    output logic                             o_drive_low,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [owtm_pkg::TEMP_W-1:0]      o_temp
);

    owtm_pkg::t_phase                 r_phase, n_phase;
    logic [owtm_pkg::TICK_W-1:0]      r_tick, n_tick;
    logic [4:0]                       r_bit_idx, n_bit_idx;
    logic                             r_byte_stage, n_byte_stage;
    logic [7:0]                       r_out_shift, n_out_shift;
    logic [owtm_pkg::TEMP_W-1:0]      r_in_shift, n_in_shift;
    logic                             r_is_read, n_is_read;
    logic [owtm_pkg::TEMP_W-1:0]      r_temp, n_temp;

    logic [owtm_pkg::TICK_W-1:0]      w_len;
    logic [owtm_pkg::TICK_W:0]        w_tick_inc;
    logic                             w_over;
    logic [4:0]                       w_bit_inc;
    logic                             w_bit;

    assign w_bit      = r_out_shift[0];
    assign w_tick_inc = {1'b0, r_tick} + (owtm_pkg::TICK_W+1)'(1);
    assign w_over     = (w_tick_inc >= {1'b0, w_len});
    assign w_bit_inc  = r_bit_idx + 5'd1;

    // length of the current phase
    always_comb begin
        unique case (r_phase)
            owtm_pkg::PH_RST_LOW: w_len = owtm_pkg::f_span(i_cfg.reset_low);
            owtm_pkg::PH_RST_REL: w_len = owtm_pkg::f_span(i_cfg.reset_rel);
            owtm_pkg::PH_GAP:     w_len = owtm_pkg::f_span(i_cfg.cmd_gap);
            owtm_pkg::PH_W_LOW:   w_len = w_bit ? owtm_pkg::f_span(i_cfg.short_low)
                                                : owtm_pkg::f_span(i_cfg.long_low);
            owtm_pkg::PH_W_REL:   w_len = w_bit ? owtm_pkg::f_span(i_cfg.long_low)
                                                : owtm_pkg::WRITE0_RELEASE;
            owtm_pkg::PH_R_LOW:   w_len = owtm_pkg::f_span(i_cfg.short_low);
            owtm_pkg::PH_R_WAIT:  w_len = owtm_pkg::f_span(i_cfg.sample_dly);
            owtm_pkg::PH_R_REC:   w_len = owtm_pkg::f_span(i_cfg.recovery);
            default:              w_len = owtm_pkg::TICK_W'(1);
        endcase
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit_idx    = r_bit_idx;
        n_byte_stage = r_byte_stage;
        n_out_shift  = r_out_shift;
        n_in_shift   = r_in_shift;
        n_is_read    = r_is_read;
        n_temp       = r_temp;

        if (r_phase != owtm_pkg::PH_IDLE) begin
            n_tick = w_over ? '0 : w_tick_inc[owtm_pkg::TICK_W-1:0];
        end

        unique case (r_phase)
            owtm_pkg::PH_RST_LOW: begin
                if (w_over) n_phase = owtm_pkg::PH_RST_REL;
            end
            owtm_pkg::PH_RST_REL, owtm_pkg::PH_GAP: begin
                if (w_over) begin
                    if (r_phase == owtm_pkg::PH_RST_REL && i_cfg.cmd_gap != '0) begin
                        n_phase = owtm_pkg::PH_GAP;
                    end else begin
                        n_byte_stage = 1'b0;
                        n_out_shift  = owtm_pkg::ROM_SKIP;
                        n_bit_idx    = '0;
                        n_phase      = owtm_pkg::PH_W_LOW;
                    end
                end
            end
            owtm_pkg::PH_W_LOW: begin
                if (w_over) n_phase = owtm_pkg::PH_W_REL;
            end
            owtm_pkg::PH_W_REL: begin
                if (w_over) begin
                    n_out_shift = {1'b0, r_out_shift[7:1]};
                    n_bit_idx   = w_bit_inc;
                    n_phase     = owtm_pkg::PH_W_LOW;
                    if (w_bit_inc >= owtm_pkg::BYTE_BITS) begin
                        n_bit_idx = '0;
                        if (!r_byte_stage) begin
                            n_byte_stage = 1'b1;
                            n_out_shift  = r_is_read ? owtm_pkg::FN_READ_SCR
                                                     : owtm_pkg::FN_CONVERT;
                        end else if (r_is_read) begin
                            n_in_shift = '0;
                            n_phase    = owtm_pkg::PH_R_LOW;
                        end else begin
                            n_phase = owtm_pkg::PH_IDLE;
                        end
                    end
                end
            end
            owtm_pkg::PH_R_LOW: begin
                if (w_over) n_phase = owtm_pkg::PH_R_WAIT;
            end
            owtm_pkg::PH_R_WAIT: begin
                if (w_over) begin
                    n_in_shift = {i_line_in, r_in_shift[owtm_pkg::TEMP_W-1:1]};
                    n_phase    = owtm_pkg::PH_R_REC;
                end
            end
            owtm_pkg::PH_R_REC: begin
                if (w_over) begin
                    n_bit_idx = w_bit_inc;
                    n_phase   = owtm_pkg::PH_R_LOW;
                    if (w_bit_inc >= owtm_pkg::READ_BITS) begin
                        n_temp    = owtm_pkg::f_tenths(r_in_shift);
                        n_bit_idx = '0;
                        n_phase   = owtm_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = owtm_pkg::PH_IDLE;
                if (i_command == owtm_pkg::CMD_CONVERT || i_command == owtm_pkg::CMD_READ) begin
                    n_is_read    = (i_command == owtm_pkg::CMD_READ);
                    n_tick       = '0;
                    n_bit_idx    = '0;
                    n_byte_stage = 1'b0;
                    n_phase      = owtm_pkg::PH_RST_LOW;
                end
            end
        endcase
    end

    // outputs of this tick
    always_comb begin
        o_drive_low = 1'b0;
        o_busy      = 1'b1;
        o_done      = 1'b0;
        unique case (r_phase)
            owtm_pkg::PH_RST_LOW, owtm_pkg::PH_W_LOW, owtm_pkg::PH_R_LOW: begin
                o_drive_low = 1'b1;
            end
            owtm_pkg::PH_RST_REL, owtm_pkg::PH_GAP, owtm_pkg::PH_R_WAIT: ;
            owtm_pkg::PH_W_REL: begin
                o_done = w_over && (w_bit_inc >= owtm_pkg::BYTE_BITS)
                         && r_byte_stage && !r_is_read;
            end
            owtm_pkg::PH_R_REC: begin
                o_done = w_over && (w_bit_inc >= owtm_pkg::READ_BITS);
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
        o_temp = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= owtm_pkg::PH_IDLE;
            r_tick       <= '0;
            r_bit_idx    <= '0;
            r_byte_stage <= 1'b0;
            r_out_shift  <= '0;
            r_in_shift   <= '0;
            r_is_read    <= 1'b0;
            r_temp       <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit_idx    <= n_bit_idx;
            r_byte_stage <= n_byte_stage;
            r_out_shift  <= n_out_shift;
            r_in_shift   <= n_in_shift;
            r_is_read    <= n_is_read;
            r_temp       <= n_temp;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/owtm_out_skid.sv
// ----------------------------------------------------------------------------
// owtm_out_skid
// Two-word output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module owtm_out_skid (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [owtm_pkg::OUT_W-1:0]    i_data,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [owtm_pkg::OUT_W-1:0]   o_data
);

    logic                        r_main_v, r_skid_v;
    logic [owtm_pkg::OUT_W-1:0]  r_main, r_skid;
    logic                        w_main_free;
    logic                        w_fire;

    assign o_ready     = !r_skid_v;
    assign w_fire      = i_valid && !r_skid_v;
    assign w_main_free = !r_main_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_main_free) begin
            r_main_v <= r_skid_v || w_fire;
            r_skid_v <= 1'b0;
        end else if (w_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_main_free) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end else if (w_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_main_v;
    assign o_data  = r_main;

endmodule

`default_nettype wire

FILE: hdl/owtm_checker.sv
// ----------------------------------------------------------------------------
// owtm_checker
// Port-level checks for one_wire_temp_sensor_master_top, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_wire_temp_sensor_master_top_assert.svh"

module owtm_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tready,
    input  wire                          m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire [owtm_pkg::OUT_W-1:0]    m_axis_tdata
);

    `OWTM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
    `OWTM_ASSERT_NOW(a_done_busy, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1], "done without busy")
    `OWTM_ASSERT_NOW(a_drive_busy, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "bus driven while idle")
    `OWTM_ASSERT_NOW(a_stall_full, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

endmodule

bind one_wire_temp_sensor_master_top owtm_checker u_owtm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
